[rtl/ufc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UART FIFO package
// Shared depths, widths, codes and types for the UART FIFO block.
// ----------------------------------------------------------------------------
package ufc_pkg;

  localparam int RX_DEPTH   = 64;
  localparam int TX_DEPTH   = 8;
  localparam int RX_FILL_W  = $clog2(RX_DEPTH + 1);
  localparam int TX_FILL_W  = $clog2(TX_DEPTH + 1);
  localparam int BYTE_W     = 8;
  localparam int MODE_W     = 2;
  localparam int WATER_W    = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CMP_W      = (RX_FILL_W > WATER_W) ? RX_FILL_W : WATER_W;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_WATER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_WATER  = 1'd1;

  localparam logic [WATER_W-1:0] HIGH_WATER_RST = 7'd32;
  localparam logic [WATER_W-1:0] LOW_WATER_RST  = 7'd8;

  typedef enum logic [MODE_W-1:0] {
    MODE_RX_BYTE    = 2'd0,
    MODE_HOST_READ  = 2'd1,
    MODE_HOST_WRITE = 2'd2,
    MODE_TX_NEXT    = 2'd3
  } mode_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_data;
    logic              rx_was_empty;
    logic [BYTE_W-1:0] tx_data;
    logic              tx_send;
    logic              tx_irq_enable;
    logic              block_sender;
    logic              overflow;
  } result_t;

endpackage
`default_nettype wire

[rtl/ufc_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UART FIFO input channel
// Valid/ready channel carrying one event transaction.
// ----------------------------------------------------------------------------
interface ufc_in_if;
  logic                       valid;
  logic                       ready;
  logic [ufc_pkg::MODE_W-1:0] mode;
  logic [ufc_pkg::BYTE_W-1:0] data;
  logic                       tx_ready;

  modport source (output valid, output mode, output data, output tx_ready, input ready);
  modport sink (input valid, input mode, input data, input tx_ready, output ready);
endinterface
`default_nettype wire

[rtl/ufc_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UART FIFO result channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface ufc_out_if;
  logic                       valid;
  logic                       ready;
  logic [ufc_pkg::BYTE_W-1:0] rx_data;
  logic                       rx_was_empty;
  logic [ufc_pkg::BYTE_W-1:0] tx_data;
  logic                       tx_send;
  logic                       tx_irq_enable;
  logic                       block_sender;
  logic                       overflow;

  modport source (output valid, output rx_data, output rx_was_empty, output tx_data,
                  output tx_send, output tx_irq_enable, output block_sender,
                  output overflow, input ready);
  modport sink (input valid, input rx_data, input rx_was_empty, input tx_data,
                input tx_send, input tx_irq_enable, input block_sender,
                input overflow, output ready);
endinterface
`default_nettype wire

[rtl/uart_fifo_with_flow_control.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UART FIFO with flow control
// Receive and transmit byte FIFOs built as chains of byte cells, with
// watermark flow control on the receive side.
//
// item carries one event per transaction: a received byte, a host read,
// a host write or a transmitter-ready request. result returns exactly one
// transaction per event, in order: the byte read, the byte to load into the
// transmitter, the interrupt enable, the sender-block line and overflow.
// cfg_we/cfg_index/cfg_data write high_water (index 0) and low_water
// (index 1); write only while no event is in flight.
// The FIFO chains and counters update at the accepting edge and the result
// is registered, so it is presented in the cycle after acceptance; one event
// per cycle is sustained while result is not stalled. Dequeues shift every cell
// of a chain toward its head; enqueues load the cell selected by the fill count.
// While result is stalled, item still accepts as long as the result
// register is free or drains in the same cycle.
// Reset clears counters, flags and the result valid and restores the
// watermarks to 32 and 8; cell contents are not cleared.
// ----------------------------------------------------------------------------
module uart_fifo_with_flow_control (
  input  wire logic                          clk,
  input  wire logic                          rst,
  ufc_in_if.sink                             item,
  ufc_out_if.source                          result,
  input  wire logic                          cfg_we,
  input  wire logic [ufc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ufc_pkg::WATER_W-1:0]   cfg_data
);

  localparam int RXD = ufc_pkg::RX_DEPTH;
  localparam int TXD = ufc_pkg::TX_DEPTH;
  localparam int RFW = ufc_pkg::RX_FILL_W;
  localparam int TFW = ufc_pkg::TX_FILL_W;

  logic [ufc_pkg::WATER_W-1:0] high_water;
  logic [ufc_pkg::WATER_W-1:0] low_water;
  logic [RFW-1:0]              rx_fill;
  logic [RFW-1:0]              rx_fill_next;
  logic [TFW-1:0]              tx_fill;
  logic [TFW-1:0]              tx_fill_next;
  logic                        sender_paused;
  logic                        sender_paused_next;
  logic                        tx_irq_on;
  logic                        tx_irq_on_next;
  logic                        out_valid;
  ufc_pkg::result_t            out_res;
  ufc_pkg::result_t            res_next;

  logic                        accept;
  logic                        rx_load;
  logic                        rx_shift;
  logic                        tx_load;
  logic                        tx_shift;
  ufc_pkg::mode_t              mode;

  logic [ufc_pkg::BYTE_W-1:0]  rx_cell [RXD];
  logic [ufc_pkg::BYTE_W-1:0]  tx_cell [TXD];

  assign item.ready = !out_valid || result.ready;
  assign accept     = item.valid && item.ready;
  assign mode       = ufc_pkg::mode_t'(item.mode);

  always_comb begin
    res_next           = '0;
    rx_fill_next       = rx_fill;
    tx_fill_next       = tx_fill;
    sender_paused_next = sender_paused;
    tx_irq_on_next     = tx_irq_on;
    rx_load            = 1'b0;
    rx_shift           = 1'b0;
    tx_load            = 1'b0;
    tx_shift           = 1'b0;
    case (mode)
      ufc_pkg::MODE_RX_BYTE: begin
        if (rx_fill == RFW'(RXD)) begin
          res_next.overflow = 1'b1;
        end else begin
          rx_load      = 1'b1;
          rx_fill_next = rx_fill + RFW'(1);
        end
        if (ufc_pkg::CMP_W'(rx_fill_next) >= ufc_pkg::CMP_W'(high_water)) begin
          sender_paused_next = 1'b1;
        end
      end
      ufc_pkg::MODE_HOST_READ: begin
        if (rx_fill == '0) begin
          res_next.rx_was_empty = 1'b1;
        end else begin
          res_next.rx_data = rx_cell[0];
          rx_shift         = 1'b1;
          rx_fill_next     = rx_fill - RFW'(1);
        end
        if (ufc_pkg::CMP_W'(rx_fill_next) <= ufc_pkg::CMP_W'(low_water)) begin
          sender_paused_next = 1'b0;
        end
      end
      ufc_pkg::MODE_HOST_WRITE: begin
        if (tx_fill == '0 && item.tx_ready) begin
          res_next.tx_data = item.data;
          res_next.tx_send = 1'b1;
        end else begin
          if (tx_fill == TFW'(TXD)) begin
            res_next.overflow = 1'b1;
          end else begin
            tx_load      = 1'b1;
            tx_fill_next = tx_fill + TFW'(1);
          end
          tx_irq_on_next = 1'b1;
        end
      end
      default: begin
        if (tx_fill != '0) begin
          res_next.tx_data = tx_cell[0];
          res_next.tx_send = 1'b1;
          tx_shift         = 1'b1;
          tx_fill_next     = tx_fill - TFW'(1);
        end
        if (tx_fill_next == '0) begin
          tx_irq_on_next = 1'b0;
        end
      end
    endcase
    res_next.tx_irq_enable = tx_irq_on_next;
    res_next.block_sender  = sender_paused_next;
  end

  for (genvar i = 0; i < RXD; i++) begin : g_rx
    ufc_pkg::cell_ctrl_t        ctrl;
    logic [ufc_pkg::BYTE_W-1:0] nbr;
    assign ctrl.load  = accept && rx_load && (rx_fill == RFW'(i));
    assign ctrl.shift = accept && rx_shift;
    if (i < RXD - 1) begin : g_mid
      assign nbr = rx_cell[i+1];
    end else begin : g_end
      assign nbr = '0;
    end
    ufc_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load_data  (item.data),
      .shift_data (nbr),
      .data       (rx_cell[i])
    );
  end

  for (genvar i = 0; i < TXD; i++) begin : g_tx
    ufc_pkg::cell_ctrl_t        ctrl;
    logic [ufc_pkg::BYTE_W-1:0] nbr;
    assign ctrl.load  = accept && tx_load && (tx_fill == TFW'(i));
    assign ctrl.shift = accept && tx_shift;
    if (i < TXD - 1) begin : g_mid
      assign nbr = tx_cell[i+1];
    end else begin : g_end
      assign nbr = '0;
    end
    ufc_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load_data  (item.data),
      .shift_data (nbr),
      .data       (tx_cell[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_water    <= ufc_pkg::HIGH_WATER_RST;
      low_water     <= ufc_pkg::LOW_WATER_RST;
      rx_fill       <= '0;
      tx_fill       <= '0;
      sender_paused <= 1'b0;
      tx_irq_on     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ufc_pkg::REG_HIGH_WATER: high_water <= cfg_data;
          ufc_pkg::REG_LOW_WATER:  low_water  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        rx_fill       <= rx_fill_next;
        tx_fill       <= tx_fill_next;
        sender_paused <= sender_paused_next;
        tx_irq_on     <= tx_irq_on_next;
        out_valid     <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= res_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.rx_data       = out_res.rx_data;
  assign result.rx_was_empty  = out_res.rx_was_empty;
  assign result.tx_data       = out_res.tx_data;
  assign result.tx_send       = out_res.tx_send;
  assign result.tx_irq_enable = out_res.tx_irq_enable;
  assign result.block_sender  = out_res.block_sender;
  assign result.overflow      = out_res.overflow;

endmodule
`default_nettype wire

[rtl/ufc_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UART FIFO cell
// One byte slot of a falling FIFO chain: load a new byte or take the
// neighbor's byte on a dequeue shift.
// ----------------------------------------------------------------------------
module ufc_cell (
  input  wire logic                       clk,
  input  wire ufc_pkg::cell_ctrl_t        ctrl,
  input  wire logic [ufc_pkg::BYTE_W-1:0] load_data,
  input  wire logic [ufc_pkg::BYTE_W-1:0] shift_data,
  output      logic [ufc_pkg::BYTE_W-1:0] data
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= load_data;
    end else if (ctrl.shift) begin
      data <= shift_data;
    end
  end

endmodule
`default_nettype wire
